FILE: hw/rtl/fslm_pkg.sv
// ----------------------------------------------------------------------------
// fslm_pkg
// Shared widths, defaults and register indexes for the 3x3 strict local
// maximum finder.
// ----------------------------------------------------------------------------
package fslm_pkg;

    // Default build parameters
    localparam int MAX_COLUMNS_DEF = 1024;
    localparam int VALUE_BITS_DEF  = 32;

    // Fixed field widths
    localparam int ROW_BITS     = 16;
    localparam int COL_CFG_BITS = 11;
    localparam int COL_OUT_BITS = 10;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_IDX_BITS  = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_ROW_COUNT    = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_COLUMN_COUNT = 1'd1;

    // Configuration reset values
    localparam logic [ROW_BITS-1:0]     ROW_COUNT_RST    = 16'd3;
    localparam logic [COL_CFG_BITS-1:0] COLUMN_COUNT_RST = 11'd3;

endpackage

FILE: hw/rtl/fslm_line_buf.sv
// ----------------------------------------------------------------------------
// fslm_line_buf
// One-row line buffer: single write port, single registered read port with
// write-to-read forwarding when both hit the same address.
// ----------------------------------------------------------------------------
module fslm_line_buf #(
    parameter int DEPTH = fslm_pkg::MAX_COLUMNS_DEF,
    parameter int WIDTH = fslm_pkg::VALUE_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Store the incoming row entry
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read; forward the write data on an address match
    always_ff @(posedge aclk) begin
        if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_reg <= wr_data;
        end else begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/first_strict_local_maximum_3x3_unit.sv
// ----------------------------------------------------------------------------
// first_strict_local_maximum_3x3_unit
// Streams a matrix in raster order and reports the first interior element
// that is strictly greater than its eight neighbors.
// ----------------------------------------------------------------------------
// The block takes one element per clock cycle unless stalled. Each transfer
// is evaluated in the cycle it is accepted: the two line buffers are read
// ahead at the next column address, so their registered outputs line up with
// the incoming element, and eight signed compares against the window center
// decide the hit. One result (found, row, column) is posted to the output
// register in the cycle after the last element of a matrix is transferred.
// The input stalls only while that output register holds a result that the
// downstream side has not yet taken. Row and column counts take effect from
// the next transfer; write them between matrices.
module first_strict_local_maximum_3x3_unit #(
    parameter int MAX_COLUMNS = fslm_pkg::MAX_COLUMNS_DEF,
    parameter int VALUE_BITS  = fslm_pkg::VALUE_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration
    input  logic                                  cfg_we,
    input  logic [fslm_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [fslm_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
    // element stream
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [VALUE_BITS-1:0]          s_value,
    // result
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_found,
    output logic [fslm_pkg::ROW_BITS-1:0]         m_row,
    output logic [fslm_pkg::COL_OUT_BITS-1:0]     m_column
);

    localparam int CNT_BITS = $clog2(MAX_COLUMNS);
    localparam int CMP_BITS = (CNT_BITS + 1 > fslm_pkg::COL_CFG_BITS) ?
                              CNT_BITS + 1 : fslm_pkg::COL_CFG_BITS;
    localparam int RB       = fslm_pkg::ROW_BITS;

    // Configuration
    logic [RB-1:0]                     row_count_reg;
    logic [fslm_pkg::COL_CFG_BITS-1:0] column_count_reg;

    // Scan state
    logic [CNT_BITS-1:0]               col_reg;
    logic [CNT_BITS-1:0]               col_next;
    logic [RB-1:0]                     row_reg;
    logic                              found_reg;
    logic [RB-1:0]                     found_row_reg;
    logic [CNT_BITS-1:0]               found_col_reg;
    logic signed [VALUE_BITS-1:0]      hist_reg [6];

    // Result register
    logic                              m_valid_reg;
    logic                              m_found_reg;
    logic [RB-1:0]                     m_row_reg;
    logic [fslm_pkg::COL_OUT_BITS-1:0] m_column_reg;

    // Datapath
    logic                              accept;
    logic [CMP_BITS-1:0]               cols_eff;
    logic [RB-1:0]                     rows_eff;
    logic                              last_col;
    logic                              last_row;
    logic                              matrix_end;
    logic [CNT_BITS-1:0]               rd_addr;
    logic [VALUE_BITS-1:0]             top_data;
    logic [VALUE_BITS-1:0]             mid_data;
    logic signed [VALUE_BITS-1:0]      win [9];
    logic                              hit;
    logic                              fin_found;
    logic [RB-1:0]                     fin_row;
    logic [CNT_BITS-1:0]               fin_col;

    assign accept  = s_valid && s_ready;
    assign s_ready = !m_valid_reg || m_ready;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg    <= fslm_pkg::ROW_COUNT_RST;
            column_count_reg <= fslm_pkg::COLUMN_COUNT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                fslm_pkg::REG_ROW_COUNT: begin
                    row_count_reg <= cfg_wdata;
                end
                fslm_pkg::REG_COLUMN_COUNT: begin
                    column_count_reg <= cfg_wdata[fslm_pkg::COL_CFG_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Effective sizes: zero means one, columns saturate at buffer depth
    always_comb begin
        if (column_count_reg == '0) begin
            cols_eff = CMP_BITS'(1);
        end else if (CMP_BITS'(column_count_reg) > CMP_BITS'(MAX_COLUMNS)) begin
            cols_eff = CMP_BITS'(MAX_COLUMNS);
        end else begin
            cols_eff = CMP_BITS'(column_count_reg);
        end
        rows_eff = (row_count_reg == '0) ? RB'(1) : row_count_reg;
    end

    // Row and matrix end detection
    assign last_col   = (CMP_BITS'(col_reg) + CMP_BITS'(1)) >= cols_eff;
    assign last_row   = ({1'b0, row_reg} + (RB+1)'(1)) >= {1'b0, rows_eff};
    assign matrix_end = last_col && last_row;
    assign col_next   = last_col ? '0 : col_reg + CNT_BITS'(1);

    // Look ahead: read the column that the next transfer will use
    assign rd_addr = accept ? col_next : col_reg;

    fslm_line_buf #(
        .DEPTH (MAX_COLUMNS),
        .WIDTH (VALUE_BITS)
    ) u_upper (
        .aclk    (aclk),
        .wr_en   (accept),
        .wr_addr (col_reg),
        .wr_data (mid_data),
        .rd_addr (rd_addr),
        .rd_data (top_data)
    );

    fslm_line_buf #(
        .DEPTH (MAX_COLUMNS),
        .WIDTH (VALUE_BITS)
    ) u_middle (
        .aclk    (aclk),
        .wr_en   (accept),
        .wr_addr (col_reg),
        .wr_data (s_value),
        .rd_addr (rd_addr),
        .rd_data (mid_data)
    );

    // Assemble the 3x3 window: two history columns plus the new column
    always_comb begin
        for (int k = 0; k < 6; k++) begin
            win[k] = hist_reg[k];
        end
        win[6] = $signed(top_data);
        win[7] = $signed(mid_data);
        win[8] = s_value;
    end

    // Center must beat all eight neighbors; interior positions only
    always_comb begin
        logic beats;
        beats = 1'b1;
        for (int k = 0; k < 9; k++) begin
            if (k != 4 && !(win[4] > win[k])) begin
                beats = 1'b0;
            end
        end
        hit = !found_reg && (row_reg >= RB'(2)) && (col_reg >= CNT_BITS'(2)) && beats;
    end

    assign fin_found = found_reg || hit;
    assign fin_row   = found_reg ? found_row_reg : row_reg - RB'(1);
    assign fin_col   = found_reg ? found_col_reg : col_reg - CNT_BITS'(1);

    // Advance the window history
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 6; k++) begin
                hist_reg[k] <= '0;
            end
        end else if (accept) begin
            for (int k = 0; k < 6; k++) begin
                hist_reg[k] <= win[k+3];
            end
        end
    end

    // Advance counters and the first-hit latch
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            row_reg       <= '0;
            found_reg     <= 1'b0;
            found_row_reg <= '0;
            found_col_reg <= '0;
        end else if (accept) begin
            col_reg <= col_next;
            if (matrix_end) begin
                row_reg       <= '0;
                found_reg     <= 1'b0;
                found_row_reg <= '0;
                found_col_reg <= '0;
            end else begin
                if (last_col) begin
                    row_reg <= row_reg + RB'(1);
                end
                found_reg     <= fin_found;
                found_row_reg <= fin_found ? fin_row : '0;
                found_col_reg <= fin_found ? fin_col : '0;
            end
        end
    end

    // Result register: load at matrix end, drop on transfer out
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept && matrix_end) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && matrix_end) begin
            m_found_reg  <= fin_found;
            m_row_reg    <= fin_found ? fin_row : '0;
            m_column_reg <= fin_found ? fslm_pkg::COL_OUT_BITS'(fin_col) : '0;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_found  = m_found_reg;
    assign m_row    = m_row_reg;
    assign m_column = m_column_reg;

    // A new result only follows an input transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(accept))
        else $error("result posted without an input transfer");

    // A latched hit never points at the first row or the first column
    assert property (@(posedge aclk) disable iff (!aresetn)
        found_reg |-> (found_row_reg != '0 && found_col_reg != '0))
        else $error("latched hit on a border element");

    // Scan state restarts after a matrix ends
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && matrix_end) |=> (col_reg == '0 && row_reg == '0 && !found_reg))
        else $error("scan state not cleared after matrix end");

    // A not-found result carries zero coordinates
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_found_reg) |-> (m_row_reg == '0 && m_column_reg == '0))
        else $error("not-found result with nonzero coordinates");

endmodule
